// File: rtl/core/sliding_window_min_max_mean_assert.svh
// Assertion macros for the sliding window statistics block.
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is high.
`define SWMMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define SWMMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SWMMM_ASSERT(lbl, prop, msg)
`define SWMMM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/core/swmmm_pkg.sv
// Shared types and constants of the sliding window statistics block.
package swmmm_pkg;

  // Width of the window size register.
  localparam int CFG_W = 7;

  // Window size after reset.
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_EVICT,
    S_SCAN,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/sliding_window_min_max_mean.sv
// Sliding window statistics: count, sum, minimum, maximum and mean of recent samples.
//
// Input channel: sample with in_valid / in_stall. A transaction is taken when in_valid is
// high and in_stall is low; in_stall is low only while the sequencer is idle.
// Output channel: fill_count, window_sum, window_min, window_max and window_mean with
// out_valid / out_stall. Every input transaction yields exactly one output transaction.
// The window size register is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// States per sample, from acceptance to the result register:
//   filling the window        : UPDATE, DIV_INIT, DIV, DONE
//   window full, no rescan    : UPDATE, EVICT, DIV_INIT, DIV, DONE
//   window full, with rescan  : UPDATE, EVICT, SCAN, DIV_INIT, DIV, DONE
// The rescan walks the sample memory through its single registered read port, and the
// mean comes from a shift-subtract divider that retires one quotient bit per cycle.
// After the result is loaded the sequencer returns to idle, where the next sample is taken;
// the block takes no new sample before it is through with the last one.
// A stalled receiver keeps the result register full; the sequencer then waits with the
// next result until the held one is taken.
// Reset (rst, synchronous) empties the window and sets the window size to 16. The sample
// memory is not cleared; only entries that were written are ever used.
`include "sliding_window_min_max_mean_assert.svh"

module sliding_window_min_max_mean #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   cfg_wr_en,
  input  logic [swmmm_pkg::CFG_W-1:0]                            cfg_wr_data,
  input  logic                                                   in_valid,
  output logic                                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]                          sample,
  output logic                                                   out_valid,
  input  logic                                                   out_stall,
  output logic [$clog2(MAX_WINDOW+1)-1:0]                        fill_count,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]       window_sum,
  output logic signed [SAMPLE_BITS-1:0]                          window_min,
  output logic signed [SAMPLE_BITS-1:0]                          window_max,
  output logic signed [SAMPLE_BITS-1:0]                          window_mean
);
  import swmmm_pkg::*;

  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W    = $clog2(MAX_WINDOW);
  localparam int SUM_W     = SAMPLE_BITS + ADDR_W;
  localparam int EXT_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Control state.
  state_t state;
  state_t state_next;
  logic [CFG_W-1:0] window_size;
  logic [CNT_W-1:0] held_count;
  logic [ADDR_W-1:0] write_slot;
  logic window_full;
  logic scan_min;
  logic scan_max;
  logic scan_first;
  logic rd_pending;
  logic [CNT_W-1:0] scan_addr;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Datapath registers.
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SAMPLE_BITS-1:0] current_min;
  logic signed [SAMPLE_BITS-1:0] current_max;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [ADDR_W-1:0] slot;
  logic [CNT_W-1:0] div_rem;
  logic [SUM_W-1:0] div_quo;
  logic div_neg;

  // Sample memory.
  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  // Combinational helpers.
  logic [EXT_W-1:0] ws_ext;
  logic [EXT_W-1:0] ws_clamp;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] held_inc;
  logic [ADDR_W-1:0] slot_sel;
  logic [CNT_W-1:0] slot_inc;
  logic [ADDR_W-1:0] slot_wrap;
  logic signed [SUM_W-1:0] s_ext;
  logic signed [SUM_W-1:0] old_ext;
  logic was_min;
  logic was_max;
  logic need_scan;
  logic scan_done;
  logic [CNT_W:0] div_trial;
  logic div_fits;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] quo_signed;
  logic out_free;

  always_comb begin
    ws_ext = EXT_W'(window_size);
    if (ws_ext == '0) begin
      ws_clamp = EXT_W'(1);
    end else if (ws_ext > EXT_W'(MAX_WINDOW)) begin
      ws_clamp = EXT_W'(MAX_WINDOW);
    end else begin
      ws_clamp = ws_ext;
    end
    w_eff = ws_clamp[CNT_W-1:0];
  end

  assign held_inc = held_count + CNT_W'(1);
  assign slot_sel = (CNT_W'(write_slot) < held_count) ? write_slot : '0;
  assign slot_inc = CNT_W'(slot) + CNT_W'(1);
  assign slot_wrap = (slot_inc >= w_eff) ? '0 : slot_inc[ADDR_W-1:0];

  assign s_ext = {{(SUM_W-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
  assign old_ext = {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
  assign was_min = (rd_data == current_min);
  assign was_max = (rd_data == current_max);
  assign need_scan = (was_min && !(in_sample < current_min)) ||
                     (was_max && !(in_sample > current_max));
  assign scan_done = !rd_pending && (scan_addr == held_count);

  assign div_trial = {div_rem, div_quo[SUM_W-1]};
  assign div_fits = (div_trial >= {1'b0, held_count});
  assign sum_mag = running_sum[SUM_W-1] ? (~running_sum + SUM_W'(1)) : running_sum;
  assign quo_signed = div_neg ? (~div_quo + SUM_W'(1)) : div_quo;
  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = window_full ? S_EVICT : S_DIV_INIT;
      end
      S_EVICT: begin
        state_next = need_scan ? S_SCAN : S_DIV_INIT;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Handshake and memory control.
  always_comb begin
    in_stall = 1'b1;
    mem_we = 1'b0;
    mem_waddr = slot;
    mem_raddr = slot_sel;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_UPDATE: begin
        mem_we = !window_full;
        mem_waddr = held_count[ADDR_W-1:0];
      end
      S_EVICT: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_raddr = scan_addr[ADDR_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_sample;
    end
    rd_data <= mem[mem_raddr];
  end

  // The result register is loaded when the sequencer finishes and emptied when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_size <= WINDOW_SIZE_RST;
      held_count <= '0;
      write_slot <= '0;
      window_full <= 1'b0;
      running_sum <= '0;
      current_min <= '0;
      current_max <= '0;
      scan_min <= 1'b0;
      scan_max <= 1'b0;
      scan_first <= 1'b0;
      rd_pending <= 1'b0;
      scan_addr <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_sample <= sample;
          end
        end
        S_UPDATE: begin
          slot <= slot_sel;
          if (!window_full) begin
            held_count <= held_inc;
            running_sum <= running_sum + s_ext;
            if (held_count == '0) begin
              current_min <= in_sample;
              current_max <= in_sample;
            end else begin
              if (in_sample < current_min) begin
                current_min <= in_sample;
              end
              if (in_sample > current_max) begin
                current_max <= in_sample;
              end
            end
            if (held_inc >= w_eff) begin
              window_full <= 1'b1;
              write_slot <= '0;
            end
          end
        end
        S_EVICT: begin
          // The evicted sample is on the read port now; the new one overwrites its slot.
          running_sum <= running_sum + s_ext - old_ext;
          if (was_min && (in_sample < current_min)) begin
            current_min <= in_sample;
          end
          if (was_max && (in_sample > current_max)) begin
            current_max <= in_sample;
          end
          scan_min <= was_min && !(in_sample < current_min);
          scan_max <= was_max && !(in_sample > current_max);
          write_slot <= slot_wrap;
          scan_addr <= '0;
          scan_first <= 1'b1;
          rd_pending <= 1'b0;
        end
        S_SCAN: begin
          // One read is issued per cycle; its data is compared in the following cycle.
          if (rd_pending) begin
            scan_first <= 1'b0;
            if (scan_min && (scan_first || (rd_data < current_min))) begin
              current_min <= rd_data;
            end
            if (scan_max && (scan_first || (rd_data > current_max))) begin
              current_max <= rd_data;
            end
          end
          if (scan_addr < held_count) begin
            scan_addr <= scan_addr + CNT_W'(1);
            rd_pending <= 1'b1;
          end else begin
            rd_pending <= 1'b0;
          end
        end
        S_DIV_INIT: begin
          div_neg <= running_sum[SUM_W-1];
          div_quo <= sum_mag;
          div_rem <= '0;
          div_cnt <= '0;
        end
        S_DIV: begin
          // Restoring division of the sum magnitude, one quotient bit per cycle.
          if (div_fits) begin
            div_rem <= CNT_W'(div_trial - {1'b0, held_count});
          end else begin
            div_rem <= div_trial[CNT_W-1:0];
          end
          div_quo <= {div_quo[SUM_W-2:0], div_fits};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            fill_count <= held_count;
            window_sum <= running_sum;
            window_min <= current_min;
            window_max <= current_max;
            window_mean <= quo_signed[SAMPLE_BITS-1:0];
          end
        end
        default: begin
          div_cnt <= '0;
        end
      endcase
    end
  end

  `SWMMM_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accepted while busy")
  `SWMMM_ASSERT(a_result_count, out_valid |-> (fill_count != '0), "result with an empty window")
  `SWMMM_ASSERT(a_min_le_max, out_valid |-> (window_min <= window_max), "minimum above maximum")
  `SWMMM_ASSERT(a_full_nonempty, window_full |-> (held_count != '0), "full window holds no samples")
  `SWMMM_ASSERT(a_scan_bound, (state == S_SCAN) |-> (scan_addr <= held_count), "rescan past window")
  `SWMMM_ASSERT_ALWAYS(a_reset_empty, (!rst && $past(rst)) |-> (!out_valid && !window_full), "state left after reset")

endmodule
